/* hw/rtl/sfcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types and constants for the sync-framed command deframer.
// ----------------------------------------------------------------------------
package sfcd_pkg;

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THIRD  = 2'd2;

  // Position within a frame.
  typedef enum logic [3:0] {
    POS_HUNT  = 4'd0,
    POS_SYNC2 = 4'd1,
    POS_SYNC3 = 4'd2,
    POS_CMD   = 4'd3,
    POS_DHI   = 4'd4,
    POS_DLO   = 4'd5,
    POS_REG   = 4'd6,
    POS_CSH   = 4'd7,
    POS_CSL   = 4'd8
  } sfcd_pos_t;

  // Expected sync byte values.
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
  } sfcd_sync_t;

  // One decoded frame, with a flag for a matching checksum.
  typedef struct packed {
    logic        hit;
    logic [7:0]  command_code;
    logic [7:0]  register_index;
    logic [15:0] data_value;
  } sfcd_result_t;

endpackage : sfcd_pkg
`default_nettype wire

/* hw/rtl/sfcd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfcd_parser
// Frame position state machine, field capture and checksum comparison.
// ----------------------------------------------------------------------------
module sfcd_parser
  import sfcd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   rx_byte,
  input  wire sfcd_sync_t   sync,
  output sfcd_result_t      result
);

  sfcd_pos_t   pos_r, pos_nxt;
  logic [7:0]  cmd_r, dhi_r, dlo_r, reg_r, csh_r;
  logic [15:0] sum;
  logic        sum_ok;

  // Position register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

  // Next position; a byte that breaks the sync sequence returns to hunting.
  always_comb begin
    unique case (pos_r)
      POS_HUNT:  pos_nxt = (rx_byte == sync.first)  ? POS_SYNC2 : POS_HUNT;
      POS_SYNC2: pos_nxt = (rx_byte == sync.second) ? POS_SYNC3 : POS_HUNT;
      POS_SYNC3: pos_nxt = (rx_byte == sync.third)  ? POS_CMD   : POS_HUNT;
      POS_CMD:   pos_nxt = POS_DHI;
      POS_DHI:   pos_nxt = POS_DLO;
      POS_DLO:   pos_nxt = POS_REG;
      POS_REG:   pos_nxt = POS_CSH;
      POS_CSH:   pos_nxt = POS_CSL;
      POS_CSL:   pos_nxt = POS_HUNT;
      default:   pos_nxt = (rx_byte == sync.first)  ? POS_SYNC2 : POS_HUNT;
    endcase
  end

  // Payload capture, one field per position.
  always_ff @(posedge clk) begin
    if (step) begin
      if (pos_r == POS_CMD) cmd_r <= rx_byte;
      if (pos_r == POS_DHI) dhi_r <= rx_byte;
      if (pos_r == POS_DLO) dlo_r <= rx_byte;
      if (pos_r == POS_REG) reg_r <= rx_byte;
      if (pos_r == POS_CSH) csh_r <= rx_byte;
    end
  end

  // Additive checksum over the sync values and the four payload bytes.
  assign sum = 16'(sync.first) + 16'(sync.second) + 16'(sync.third)
             + 16'(cmd_r) + 16'(dhi_r) + 16'(dlo_r) + 16'(reg_r);
  assign sum_ok = (sum == {csh_r, rx_byte});

  // Result for the final checksum byte.
  assign result.hit            = step && (pos_r == POS_CSL) && sum_ok;
  assign result.command_code   = cmd_r;
  assign result.register_index = reg_r;
  assign result.data_value     = {dhi_r, dlo_r};

`ifndef SYNTH
  // A result comes only from the last checksum byte.
  a_hit_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    result.hit |-> (step && pos_r == POS_CSL))
    else $error("result outside the checksum low position");

  // After the last checksum byte the parser always hunts again.
  a_back_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (step && pos_r == POS_CSL) |=> (pos_r == POS_HUNT))
    else $error("no return to hunting after a frame");

  // A mismatching second sync byte is consumed and not retried as a first.
  a_broken_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (step && pos_r == POS_SYNC2 && rx_byte != sync.second) |=> (pos_r == POS_HUNT))
    else $error("broken sync did not return to hunting");
`endif

endmodule : sfcd_parser
`default_nettype wire

/* hw/rtl/sfcd_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfcd_out_reg
// Result register on the output channel, with the pipeline advance signal.
// ----------------------------------------------------------------------------
module sfcd_out_reg
  import sfcd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire sfcd_result_t result,
  output logic              advance,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_command_code,
  output logic [7:0]        out_register_index,
  output logic [15:0]       out_data_value
);

  logic        valid_r;
  logic [7:0]  cmd_r;
  logic [7:0]  reg_r;
  logic [15:0] data_r;

  // The pipeline moves whenever the register is empty or being emptied.
  assign advance = !valid_r || !out_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= result.hit;
    end
  end

  // Payload is loaded only with a new result, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (advance && result.hit) begin
      cmd_r  <= result.command_code;
      reg_r  <= result.register_index;
      data_r <= result.data_value;
    end
  end

  assign out_valid          = valid_r;
  assign out_command_code   = cmd_r;
  assign out_register_index = reg_r;
  assign out_data_value     = data_r;

endmodule : sfcd_out_reg
`default_nettype wire

/* hw/rtl/sync_framed_command_deframer_core.sv */
`default_nettype none
// Path: the last checksum byte is held in the input register, and the parser's
// result for it is loaded into the result register when the pipeline advances;
// out_valid is the valid flag of that result register.
// Throughput: one byte per cycle; transfers pause only while a result is stalled.
// Reset: synchronous, active low; clears the sync registers to zero, the frame
// position to hunting and both valid flags. No clearing pass is needed.
// ----------------------------------------------------------------------------
// sync_framed_command_deframer_core
// Scans received bytes for sync-framed commands and emits checked commands.
// ----------------------------------------------------------------------------
module sync_framed_command_deframer_core
  import sfcd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_byte,
  // Result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_command_code,
  output logic [7:0]                out_register_index,
  output logic [15:0]               out_data_value,
  // Configuration port
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  sfcd_sync_t   sync_r;
  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         advance;
  sfcd_result_t result;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Sync value registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_r.first  <= cfg_data;
        CFG_SYNC_SECOND: sync_r.second <= cfg_data;
        CFG_SYNC_THIRD:  sync_r.third  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register, moving with the pipeline.
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (advance) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Frame parsing and checksum check.
  sfcd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_valid_r && advance),
    .rx_byte (in_byte_r),
    .sync    (sync_r),
    .result  (result)
  );

  // Result register.
  sfcd_out_reg u_out_reg (
    .clk                (clk),
    .rst_n              (rst_n),
    .result             (result),
    .advance            (advance),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_command_code   (out_command_code),
    .out_register_index (out_register_index),
    .out_data_value     (out_data_value)
  );

endmodule : sync_framed_command_deframer_core
`default_nettype wire

/* tb/sync_framed_command_deframer_core_tb.sv */
// ----------------------------------------------------------------------------
// Sync-framed command deframer testbench
// Streams received bytes into the deframer under random source gaps and
// result stalls. A shadow deframer works out each expected command as its
// bytes are transferred. The monitor then checks every command leaving the
// block, field by field, in order.
// ----------------------------------------------------------------------------
module sync_framed_command_deframer_core_tb
  import sfcd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Index that decodes to no register; writes to it must have no effect.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT = 1_000_000;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned RANDOM_PHASES = 8;

  // One checked command as it leaves the block.
  typedef struct packed {
    logic [7:0]  command_code;
    logic [7:0]  register_index;
    logic [15:0] data_value;
  } deframed_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte = 8'd0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_command_code;
  logic [7:0]           out_register_index;
  logic [15:0]          out_data_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_FIRST;
  logic [7:0]           cfg_data = 8'd0;

  // Bytes waiting to be sent, and commands waiting to come out.
  logic [7:0]    tx_bytes[$];
  deframed_cmd_t awaited_cmds[$];
  deframed_cmd_t head_cmd;

  // Sync values that the traffic generator frames with.
  sfcd_sync_t  link_sync = '0;
  int unsigned bytes_queued = 0;

  // Shadow copy of the deframer state and its registers.
  sfcd_sync_t  shadow_sync = '0;
  sfcd_pos_t   shadow_pos = POS_HUNT;
  logic [7:0]  shadow_cmd = 8'd0;
  logic [7:0]  shadow_dhi = 8'd0;
  logic [7:0]  shadow_dlo = 8'd0;
  logic [7:0]  shadow_reg = 8'd0;
  logic [7:0]  shadow_csh = 8'd0;

  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned out_hold = 0;
  int unsigned out_calm = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  sync_framed_command_deframer_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_command_code  (out_command_code),
    .out_register_index(out_register_index),
    .out_data_value    (out_data_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // Length of the next idle stretch: mostly none or short, a few long, and
  // now and then a calm run with no idling at all.
  function automatic int unsigned pick_idle_len(inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advances the shadow deframer by one transferred byte and records the
  // command that a completed, correctly summed frame yields.
  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0]   sum;
    deframed_cmd_t cmd;
    case (shadow_pos)
      POS_SYNC2: shadow_pos = (b == shadow_sync.second) ? POS_SYNC3 : POS_HUNT;
      POS_SYNC3: shadow_pos = (b == shadow_sync.third) ? POS_CMD : POS_HUNT;
      POS_CMD: begin
        shadow_cmd = b;
        shadow_pos = POS_DHI;
      end
      POS_DHI: begin
        shadow_dhi = b;
        shadow_pos = POS_DLO;
      end
      POS_DLO: begin
        shadow_dlo = b;
        shadow_pos = POS_REG;
      end
      POS_REG: begin
        shadow_reg = b;
        shadow_pos = POS_CSH;
      end
      POS_CSH: begin
        shadow_csh = b;
        shadow_pos = POS_CSL;
      end
      POS_CSL: begin
        shadow_pos = POS_HUNT;
        sum = {8'd0, shadow_sync.first} + {8'd0, shadow_sync.second}
            + {8'd0, shadow_sync.third} + {8'd0, shadow_cmd} + {8'd0, shadow_reg}
            + {8'd0, shadow_dhi} + {8'd0, shadow_dlo};
        if ({shadow_csh, b} == sum) begin
          cmd.command_code   = shadow_cmd;
          cmd.register_index = shadow_reg;
          cmd.data_value     = {shadow_dhi, shadow_dlo};
          awaited_cmds.push_back(cmd);
        end
      end
      default: shadow_pos = (b == shadow_sync.first) ? POS_SYNC2 : POS_HUNT;
    endcase
  endtask

  // Register writes are mirrored into the shadow copy as they transfer.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  shadow_sync.first <= cfg_data;
        CFG_SYNC_SECOND: shadow_sync.second <= cfg_data;
        CFG_SYNC_THIRD:  shadow_sync.third <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte driver: predicts on every transfer, then offers the next byte or a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= tx_bytes.pop_front();
          in_gap = pick_idle_len(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Command monitor: checks each transfer against the oldest expectation and
  // applies random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_cmds.size() == 0) begin
          $error("unexpected command: command_code %0h register_index %0h data_value %0h",
                 out_command_code, out_register_index, out_data_value);
          fail_count++;
        end else begin
          head_cmd = awaited_cmds.pop_front();
          if (out_command_code !== head_cmd.command_code) begin
            $error("command_code: expected %0h, got %0h",
                   head_cmd.command_code, out_command_code);
            fail_count++;
          end
          if (out_register_index !== head_cmd.register_index) begin
            $error("register_index: expected %0h, got %0h",
                   head_cmd.register_index, out_register_index);
            fail_count++;
          end
          if (out_data_value !== head_cmd.data_value) begin
            $error("data_value: expected %0h, got %0h",
                   head_cmd.data_value, out_data_value);
            fail_count++;
          end
        end
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
        out_hold = pick_idle_len(out_calm);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("sync_framed_command_deframer_core verification failed");
      $finish;
    end
  end

  function automatic void send_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // Field byte with extra weight on the extremes.
  function automatic logic [7:0] pick_field_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // A byte that differs from x, often the first sync value so that a broken
  // sequence could be mistaken for the start of a new frame.
  function automatic logic [7:0] pick_mismatch(input logic [7:0] x);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 2) == 0) b = link_sync.first;
    if (b == x) b = x ^ (8'h01 << $urandom_range(0, 7));
    return b;
  endfunction

  // Queues a whole frame; a spoilt frame carries a wrong checksum.
  function automatic void send_frame(input logic [7:0] cmd, input logic [7:0] dhi,
                                     input logic [7:0] dlo, input logic [7:0] regv,
                                     input bit spoil);
    logic [15:0] sum;
    sum = {8'd0, link_sync.first} + {8'd0, link_sync.second} + {8'd0, link_sync.third}
        + {8'd0, cmd} + {8'd0, dhi} + {8'd0, dlo} + {8'd0, regv};
    if (spoil) sum = sum ^ 16'($urandom_range(1, 65535));
    send_byte(link_sync.first);
    send_byte(link_sync.second);
    send_byte(link_sync.third);
    send_byte(cmd);
    send_byte(dhi);
    send_byte(dlo);
    send_byte(regv);
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
  endfunction

  // Mostly well-formed frames with random content, the rest noise, broken
  // sync sequences and truncated frames.
  task automatic send_traffic(input int unsigned n);
    int unsigned target;
    int unsigned r;
    int unsigned len;
    target = bytes_queued + n;
    while (bytes_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(pick_field_byte(), pick_field_byte(), pick_field_byte(),
                   pick_field_byte(), $urandom_range(0, 4) == 0);
      end else if (r < 80) begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          if ($urandom_range(0, 9) < 3) send_byte(link_sync.first);
          else send_byte(8'($urandom_range(0, 255)));
        end
      end else if (r < 90) begin
        send_byte(link_sync.first);
        if ($urandom_range(0, 1) == 0) begin
          send_byte(pick_mismatch(link_sync.second));
        end else begin
          send_byte(link_sync.second);
          send_byte(pick_mismatch(link_sync.third));
        end
      end else begin
        send_byte(link_sync.first);
        send_byte(link_sync.second);
        send_byte(link_sync.third);
        len = $urandom_range(0, 5);
        repeat (len) send_byte(pick_field_byte());
      end
    end
  endtask

  // Writes the three sync registers, and optionally the unused index, while
  // the block is idle. Valid stays high between back-to-back writes.
  task automatic program_sync(input sfcd_sync_t s, input bit poke_unused);
    logic [CFG_IDX_W-1:0] idx_list [4];
    logic [7:0]           val_list [4];
    int unsigned          n_writes;
    idx_list[0] = CFG_SYNC_FIRST;
    idx_list[1] = CFG_SYNC_SECOND;
    idx_list[2] = CFG_SYNC_THIRD;
    idx_list[3] = CFG_UNUSED;
    val_list[0] = s.first;
    val_list[1] = s.second;
    val_list[2] = s.third;
    val_list[3] = 8'($urandom_range(0, 255));
    n_writes = poke_unused ? 4 : 3;
    for (int k = 0; k < n_writes; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data  <= val_list[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    link_sync = s;
  endtask

  // Waits until every byte has transferred and every command has come out,
  // then lets the pipeline settle.
  task automatic wait_for_quiet();
    while (tx_bytes.size() != 0 || in_valid || awaited_cmds.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Test sequence.
  initial begin
    sfcd_sync_t s;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: an all-zero frame is a valid command.
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    wait_for_quiet();

    // Directed: full-scale payload, sync broken at the second and at the
    // third byte by a first-sync value, and a frame with a bad checksum.
    program_sync({8'hA5, 8'h5A, 8'hC3}, 1'b1);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_byte(8'hA5);
    send_byte(8'hA5);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_frame(8'h12, 8'h34, 8'h56, 8'h78, 1'b1);
    wait_for_quiet();

    // Random traffic across several sync settings, extremes first.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: s = {8'hFF, 8'hFF, 8'hFF};
        1: s = {8'h00, 8'hFF, 8'h00};
        2: s = {8'hFF, 8'h00, 8'hFF};
        default: s = sfcd_sync_t'(24'($urandom));
      endcase
      program_sync(s, $urandom_range(0, 1) == 1);
      send_traffic(PHASE_ITEMS);
      wait_for_quiet();
    end

    if (awaited_cmds.size() != 0) begin
      $error("%0d expected commands never arrived", awaited_cmds.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("sync_framed_command_deframer_core verification clean");
    end else begin
      $display("sync_framed_command_deframer_core verification failed");
    end
    $finish;
  end

endmodule
